// ===== hdl/ccf_pkg.sv =====
`timescale 1ns / 1ps

package ccf_pkg;

  localparam logic [10:0] STATUS_ID   = 11'h54B;
  localparam logic [10:0] FIRST_ID    = 11'h540;
  localparam logic [10:0] SECOND_ID   = 11'h541;
  localparam logic [7:0]  READY_BYTE0 = 8'h60;
  localparam logic [7:0]  BYTE1_RUN   = 8'h40;
  localparam logic [7:0]  BYTE6_RUN   = 8'h04;
  localparam logic [7:0]  DRV_OFFSET  = 8'hB8;
  localparam logic [7:0]  PAS_OFFSET  = 8'h33;
  localparam logic [7:0]  STAT_MASK   = 8'hA0;
  localparam logic [7:0]  STAT_REJECT = 8'h20;
  localparam logic [3:0]  MIN_LEN     = 4'd8;
  localparam logic [8:0]  TICK_MAX    = 9'd511;

  localparam logic [63:0] FIRST_RESET  = 64'h0000_0000_0000_0080;
  localparam logic [63:0] SECOND_RESET = 64'h0000_0000_0000_8000;
  localparam logic [7:0]  HS_PERIOD_RESET  = 8'd100;
  localparam logic [7:0]  ONL_PERIOD_RESET = 8'd200;

  localparam logic CFG_HANDSHAKE = 1'b0;
  localparam logic CFG_ONLINE    = 1'b1;

  typedef enum logic [1:0] {
    REQ_FRAME = 2'd0,
    REQ_CMD   = 2'd1,
    REQ_TICK  = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    CMD_OFF      = 4'd0,
    CMD_AUTO     = 4'd1,
    CMD_AC       = 4'd2,
    CMD_DUAL     = 4'd3,
    CMD_RECIRC   = 4'd4,
    CMD_MODE     = 4'd5,
    CMD_FRONTDEF = 4'd6,
    CMD_REARDEF  = 4'd7,
    CMD_FAN_UP   = 4'd8,
    CMD_FAN_DOWN = 4'd9,
    CMD_DRV_TEMP = 4'd10,
    CMD_PAS_TEMP = 4'd11
  } cmd_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
    logic [3:0]  command;
    logic [7:0]  temp_value;
  } item_t;

  typedef struct packed {
    logic [63:0] first;
    logic [63:0] second;
    logic        rdy;
  } pair_t;

endpackage

// ===== hdl/climate_can_control_frames_top.sv =====
`timescale 1ns / 1ps
// path: input register, then a sending tick loads the pair register, which offers beat one
// throughput: one input beat per cycle while no tick waits for the output
// a sending tick holds the output for two beats, any tick waits while an earlier pair
// is still going out, the pair register reloads as the last beat of the previous pair leaves
// asynchronous active-low reset: first frame byte0 0x80, second frame byte1 0x80,
// offline, frames marked changed, tick count 0, periods 100 and 200

module climate_can_control_frames_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // frame_id, frame_len, frame_data, command, temp_value, zero pad
  input  logic [95:0] s_axis_tdata,
  // req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_id, out_data, zero pad
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // unit_ready
  output logic [0:0]  m_axis_tuser
);

  logic           in_valid_q;
  ccf_pkg::item_t item_q;
  ccf_pkg::item_t item_d;
  logic           consume;
  logic           send_ok;
  logic           load;
  ccf_pkg::pair_t pair;

  assign s_axis_tready = !in_valid_q || consume;

  always_comb begin
    item_d.req_type   = s_axis_tuser;
    item_d.frame_id   = s_axis_tdata[10:0];
    item_d.frame_len  = s_axis_tdata[14:11];
    item_d.frame_data = s_axis_tdata[78:15];
    item_d.command    = s_axis_tdata[82:79];
    item_d.temp_value = s_axis_tdata[90:83];
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  ccf_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (in_valid_q),
    .item_i       (item_q),
    .send_ok_i    (send_ok),
    .consume_o    (consume),
    .load_o       (load),
    .pair_o       (pair)
  );

  ccf_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .pair_i        (pair),
    .send_ok_o     (send_ok),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== hdl/ccf_core.sv =====
`timescale 1ns / 1ps

module ccf_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [7:0]     cfg_data_i,
  input  logic           item_valid_i,
  input  ccf_pkg::item_t item_i,
  input  logic           send_ok_i,
  output logic           consume_o,
  output logic           load_o,
  output ccf_pkg::pair_t pair_o
);

  logic [63:0] first_q, first_d;
  logic [63:0] second_q, second_d;
  logic        online_q, online_d;
  logic        changed_q, changed_d;
  logic [8:0]  ticks_q, ticks_d;
  logic [7:0]  hs_q, onl_q;
  logic [8:0]  ticks_inc;
  logic [7:0]  period;
  logic        rdy;
  logic        fire;

  assign rdy       = (first_q[7:0] == ccf_pkg::READY_BYTE0);
  assign ticks_inc = (ticks_q == ccf_pkg::TICK_MAX) ? ticks_q : ticks_q + 9'd1;
  assign period    = online_q ? onl_q : hs_q;
  assign fire      = item_valid_i &&
                     ((item_i.req_type != ccf_pkg::REQ_TICK) || send_ok_i);
  assign consume_o = fire;

  always_comb begin
    first_d   = first_q;
    second_d  = second_q;
    online_d  = online_q;
    changed_d = changed_q;
    ticks_d   = ticks_q;
    load_o    = 1'b0;
    if (fire) begin
      case (item_i.req_type)
        ccf_pkg::REQ_FRAME: begin
          if (item_i.frame_id == ccf_pkg::STATUS_ID && item_i.frame_len >= ccf_pkg::MIN_LEN
              && !online_q
              && (item_i.frame_data[7:0] & ccf_pkg::STAT_MASK) != ccf_pkg::STAT_REJECT) begin
            online_d      = 1'b1;
            first_d[7:0]  = 8'h00;
            changed_d     = 1'b1;
          end
        end
        ccf_pkg::REQ_CMD: begin
          if (rdy) begin
            changed_d = 1'b1;
            case (item_i.command)
              ccf_pkg::CMD_OFF:      first_d[55]  = ~first_q[55];
              ccf_pkg::CMD_AUTO:     first_d[53]  = ~first_q[53];
              ccf_pkg::CMD_AC:       first_d[43]  = ~first_q[43];
              ccf_pkg::CMD_DUAL:     first_d[51]  = ~first_q[51];
              ccf_pkg::CMD_RECIRC:   second_d[14] = ~second_q[14];
              ccf_pkg::CMD_MODE:     first_d[48]  = ~first_q[48];
              ccf_pkg::CMD_FRONTDEF: first_d[49]  = ~first_q[49];
              ccf_pkg::CMD_FAN_UP:   second_d[5]  = ~second_q[5];
              ccf_pkg::CMD_FAN_DOWN: second_d[4]  = ~second_q[4];
              ccf_pkg::CMD_DRV_TEMP: begin
                first_d[45]    = ~first_q[45];
                first_d[31:24] = item_i.temp_value + ccf_pkg::DRV_OFFSET;
              end
              ccf_pkg::CMD_PAS_TEMP: begin
                first_d[45]    = ~first_q[45];
                first_d[39:32] = item_i.temp_value - ccf_pkg::PAS_OFFSET;
              end
              default: changed_d = changed_q;
            endcase
          end
        end
        ccf_pkg::REQ_TICK: begin
          if (changed_q || ticks_inc > {1'b0, period}) begin
            load_o = 1'b1;
            if (online_q && first_q[7:0] == 8'h00) begin
              first_d[7:0]   = ccf_pkg::READY_BYTE0;
              first_d[15:8]  = ccf_pkg::BYTE1_RUN;
              first_d[55:48] = ccf_pkg::BYTE6_RUN;
            end
            changed_d = 1'b0;
            ticks_d   = '0;
          end else begin
            ticks_d = ticks_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    pair_o.first  = first_q;
    pair_o.second = second_q;
    pair_o.rdy    = rdy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= ccf_pkg::FIRST_RESET;
      second_q  <= ccf_pkg::SECOND_RESET;
      online_q  <= 1'b0;
      changed_q <= 1'b1;
      ticks_q   <= '0;
    end else begin
      first_q   <= first_d;
      second_q  <= second_d;
      online_q  <= online_d;
      changed_q <= changed_d;
      ticks_q   <= ticks_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q  <= ccf_pkg::HS_PERIOD_RESET;
      onl_q <= ccf_pkg::ONL_PERIOD_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ccf_pkg::CFG_HANDSHAKE) begin
        hs_q <= cfg_data_i;
      end else begin
        onl_q <= cfg_data_i;
      end
    end
  end

`ifndef SYNTHESIS
  a_online_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    online_q |=> online_q) else $error("unit went offline");

  a_tick_clears_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && item_i.req_type == ccf_pkg::REQ_TICK) |=> !changed_q)
    else $error("change flag survived a tick");

  a_send_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o |-> (send_ok_i && item_i.req_type == ccf_pkg::REQ_TICK))
    else $error("pair loaded outside a tick");
`endif

endmodule

// ===== hdl/ccf_out.sv =====
`timescale 1ns / 1ps

module ccf_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  ccf_pkg::pair_t pair_i,
  output logic           send_ok_o,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [79:0]    m_axis_tdata,
  output logic           m_axis_tlast,
  output logic [0:0]     m_axis_tuser
);

  logic           valid_q;
  logic           beat_q;
  ccf_pkg::pair_t pair_q;
  logic [10:0]    id;
  logic [63:0]    data;

  assign send_ok_o     = !valid_q || (beat_q && m_axis_tready);
  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = beat_q;
  assign m_axis_tuser  = pair_q.rdy;
  assign id            = beat_q ? ccf_pkg::SECOND_ID : ccf_pkg::FIRST_ID;
  assign data          = beat_q ? pair_q.second : pair_q.first;
  assign m_axis_tdata  = {5'b0, data, id};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pair_q <= pair_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      beat_q  <= 1'b0;
    end else if (valid_q && m_axis_tready) begin
      valid_q <= !beat_q;
      beat_q  <= !beat_q;
    end
  end

`ifndef SYNTHESIS
  a_beat_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q |-> !beat_q) else $error("second beat index without pair");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> send_ok_o) else $error("pair overwritten before sent");

  a_first_then_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !beat_q && m_axis_tready) |=> (valid_q && beat_q))
    else $error("second beat missing");
`endif

endmodule
